>>> rtl/core/plal_pkg.sv
package plal_pkg;

  // polyline geometry
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 32;
  localparam int LEN_W      = 32;
  localparam int TOL_W      = 16;

  // operation codes on the input channel
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // status codes on the output channel
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CLAMPED = 2'd1;
  localparam logic [1:0] ST_FEW     = 2'd2;

  // serial arithmetic unit commands
  localparam logic [1:0] AR_MUL_CLR = 2'd0;
  localparam logic [1:0] AR_MUL_ACC = 2'd1;
  localparam logic [1:0] AR_SQRT    = 2'd2;
  localparam logic [1:0] AR_DIV     = 2'd3;

  localparam int MAG_W = COORD_W + 1;
  localparam int ACC_W = 2 * MAG_W;
  localparam int QUO_W = COORD_W + 2;

  typedef struct packed {
    logic               start;
    logic [1:0]         op;
    logic [MAG_W-1:0]   a;
    logic [MAG_W-1:0]   b;
    logic [LEN_W-1:0]   divisor;
  } arith_cmd_t;

  typedef struct packed {
    logic               done;
    logic [ACC_W-1:0]   acc;
    logic [LEN_W-1:0]   root;
    logic [QUO_W-1:0]   quo;
    logic               quo_ovf;
  } arith_rsp_t;

endpackage

>>> rtl/core/plal_in_if.sv
interface plal_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        op;
  logic signed [plal_pkg::COORD_W-1:0] vertex_x;
  logic signed [plal_pkg::COORD_W-1:0] vertex_y;
  logic [plal_pkg::LEN_W-1:0]        position;

  modport source (output valid, output op, output vertex_x, output vertex_y,
                  output position, input ready);
  modport sink (input valid, input op, input vertex_x, input vertex_y,
                input position, output ready);
endinterface

>>> rtl/core/plal_out_if.sv
interface plal_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [plal_pkg::COORD_W-1:0] point_x;
  logic signed [plal_pkg::COORD_W-1:0] point_y;
  logic [plal_pkg::IDX_W-1:0]          segment_index;
  logic                                at_vertex;
  logic                                at_endpoint;
  logic [1:0]                          status;

  modport source (output valid, output point_x, output point_y,
                  output segment_index, output at_vertex, output at_endpoint,
                  output status, input ready);
  modport sink (input valid, input point_x, input point_y,
                input segment_index, input at_vertex, input at_endpoint,
                input status, output ready);
endinterface

>>> rtl/core/plal_arith.sv
// Bit-serial multiply-accumulate, square root and divide on one accumulator.
module plal_arith (
  input  logic                  clk,
  input  logic                  rst,
  input  plal_pkg::arith_cmd_t  cmd,
  output plal_pkg::arith_rsp_t  rsp
);
  import plal_pkg::*;

  localparam logic [6:0] MUL_STEPS  = 7'(MAG_W);
  localparam logic [6:0] SQRT_STEPS = 7'(LEN_W);
  localparam logic [6:0] DIV_STEPS  = 7'(ACC_W - 1);

  logic             busy;
  logic             done;
  logic [1:0]       op_r;
  logic [6:0]       cnt;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] mc;
  logic [MAG_W-1:0] mp;
  logic [34:0]      part;
  logic [LEN_W-1:0] root;
  logic [LEN_W-1:0] dvs;
  logic [QUO_W-1:0] quo;
  logic             ovf;

  logic [34:0]      sq_sh;
  logic [34:0]      sq_trial;
  logic             sq_ge;
  logic [32:0]      dv_sh;
  logic             dv_ge;

  // one digit of the root / quotient per cycle
  always_comb begin
    sq_sh    = {part[32:0], acc[63:62]};
    sq_trial = {1'b0, root, 2'b01};
    sq_ge    = (sq_sh >= sq_trial);
    dv_sh    = {part[31:0], acc[ACC_W-2]};
    dv_ge    = (dv_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !cmd.start && busy && (cnt == 7'd1);
      if (cmd.start) begin
        busy <= 1'b1;
        op_r <= cmd.op;
        unique case (cmd.op)
          AR_MUL_CLR, AR_MUL_ACC: begin
            if (cmd.op == AR_MUL_CLR) acc <= '0;
            mc  <= {{MAG_W{1'b0}}, cmd.a};
            mp  <= cmd.b;
            cnt <= MUL_STEPS;
          end
          AR_SQRT: begin
            part <= '0;
            root <= '0;
            cnt  <= SQRT_STEPS;
          end
          default: begin
            part <= '0;
            quo  <= '0;
            ovf  <= 1'b0;
            dvs  <= cmd.divisor;
            cnt  <= DIV_STEPS;
          end
        endcase
      end else if (busy) begin
        unique case (op_r)
          AR_MUL_CLR, AR_MUL_ACC: begin
            if (mp[0]) acc <= acc + mc;
            mc <= {mc[ACC_W-2:0], 1'b0};
            mp <= {1'b0, mp[MAG_W-1:1]};
          end
          AR_SQRT: begin
            if (sq_ge) begin
              part <= sq_sh - sq_trial;
              root <= {root[LEN_W-2:0], 1'b1};
            end else begin
              part <= sq_sh;
              root <= {root[LEN_W-2:0], 1'b0};
            end
            acc <= {acc[ACC_W-3:0], 2'b00};
          end
          default: begin
            if (dv_ge) part <= {2'b00, dv_sh - {1'b0, dvs}};
            else       part <= {2'b00, dv_sh};
            quo <= {quo[QUO_W-2:0], dv_ge};
            ovf <= ovf | quo[QUO_W-1];
            acc <= {acc[ACC_W-2:0], 1'b0};
          end
        endcase
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) busy <= 1'b0;
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.acc     = acc;
  assign rsp.root    = root;
  assign rsp.quo     = quo;
  assign rsp.quo_ovf = ovf;

endmodule

>>> rtl/core/polyline_arc_length_point_top.sv
// Channel   Role   Beat
// cmd       sink   op, vertex_x, vertex_y, position
// res       source point_x, point_y, segment_index, at_vertex, at_endpoint, status
// cfg_*     write  vertex_tolerance (16 bits), one register
//
// One beat at a time. Clear and the first append finish without leaving idle; later
// appends run two serial squares and a serial root (skipped if the sum saturates).
// A query runs a scan of up to 62 stored lengths, fetches of the segment ends and
// of the first and last vertex, the segment length, then per axis a serial multiply
// and a serial divide. Reset empties the polyline and sets the tolerance to 1.
// cmd is taken again while a result waits in the output register; a finished
// query holds until that register is free.
module polyline_arc_length_point_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [plal_pkg::TOL_W-1:0]   cfg_wdata,
  plal_in_if.sink                      cmd,
  plal_out_if.source                   res
);
  import plal_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_FETCH    = 4'd2;
  localparam logic [3:0] S_LEN_GO   = 4'd3;
  localparam logic [3:0] S_LEN_X    = 4'd4;
  localparam logic [3:0] S_LEN_Y    = 4'd5;
  localparam logic [3:0] S_LEN_SQ   = 4'd6;
  localparam logic [3:0] S_LEN_DONE = 4'd7;
  localparam logic [3:0] S_Q_SETUP  = 4'd8;
  localparam logic [3:0] S_Q_MUL    = 4'd9;
  localparam logic [3:0] S_Q_DIV    = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_POINTS);
  localparam logic [QUO_W-1:0] Q_CLAMP  = QUO_W'(1) << (COORD_W + 1);
  localparam logic [LEN_W-1:0] LEN_SAT  = '1;

  // storage
  logic [COORD_W-1:0] mem_x   [MAX_POINTS];
  logic [COORD_W-1:0] mem_y   [MAX_POINTS];
  logic [LEN_W-1:0]   mem_cum [MAX_POINTS];
  logic [IDX_W-1:0]   rd_addr;
  logic [COORD_W-1:0] rd_x, rd_y;
  logic [LEN_W-1:0]   rd_cum;

  // control
  logic [3:0]         state;
  logic [CNT_W-1:0]   count;
  logic [TOL_W-1:0]   tol;
  logic               is_query;
  logic               few;
  logic               axis;
  logic [IDX_W-1:0]   scan_i;
  logic               chk_v;
  logic [IDX_W-1:0]   chk_i;
  logic [2:0]         fcnt;
  logic               out_valid;

  // datapath registers
  logic [IDX_W-1:0]   idx;
  logic [LEN_W-1:0]   pos_r;
  logic [COORD_W-1:0] sa_x, sa_y, sb_x, sb_y;
  logic [COORD_W-1:0] x0, y0, xl, yl;
  logic [LEN_W-1:0]   cum_idx, total, prev_cum, seg_len, rem;
  logic               vtx;
  logic [COORD_W-1:0] px, py;
  logic [COORD_W-1:0] o_px, o_py;
  logic [IDX_W-1:0]   o_idx;
  logic               o_vtx, o_endp;
  logic [1:0]         o_status;

  arith_cmd_t         acmd;
  arith_rsp_t         arsp;

  logic               accept;
  logic [IDX_W-1:0]   last;
  logic [MAG_W-1:0]   diff_x, diff_y, udx, udy;
  logic               neg_x, neg_y;
  logic [LEN_W-1:0]   cum_sum;
  logic               cum_ovf;
  logic [COORD_W-1:0] p_new;
  logic               endp;
  logic               out_free;

  plal_arith u_arith (
    .clk (clk),
    .rst (rst),
    .cmd (acmd),
    .rsp (arsp)
  );

  // point advanced along an axis by the clamped quotient, saturated
  function automatic logic [COORD_W-1:0] step_sat(input logic [COORD_W-1:0] start,
                                                  input logic neg,
                                                  input logic [QUO_W-1:0] q,
                                                  input logic ovf);
    logic [QUO_W-1:0] qc;
    logic [QUO_W:0]   s_ext;
    logic [QUO_W:0]   p;
    logic [QUO_W:0]   pmax;
    logic [QUO_W:0]   pmin;
    qc    = (ovf || q > Q_CLAMP) ? Q_CLAMP : q;
    s_ext = {{(QUO_W + 1 - COORD_W){start[COORD_W-1]}}, start};
    p     = neg ? s_ext - {1'b0, qc} : s_ext + {1'b0, qc};
    pmax  = {{(QUO_W + 2 - COORD_W){1'b0}}, {(COORD_W - 1){1'b1}}};
    pmin  = {{(QUO_W + 2 - COORD_W){1'b1}}, {(COORD_W - 1){1'b0}}};
    if (!p[QUO_W] && p > pmax)                step_sat = {1'b0, {(COORD_W - 1){1'b1}}};
    else if (p[QUO_W] && $signed(p) < $signed(pmin)) step_sat = {1'b1, {(COORD_W - 1){1'b0}}};
    else                                      step_sat = p[COORD_W-1:0];
  endfunction

  // segment deltas and magnitudes, running sum, stepped point and end flags
  always_comb begin
    diff_x = {sb_x[COORD_W-1], sb_x} - {sa_x[COORD_W-1], sa_x};
    diff_y = {sb_y[COORD_W-1], sb_y} - {sa_y[COORD_W-1], sa_y};
    neg_x  = diff_x[MAG_W-1];
    neg_y  = diff_y[MAG_W-1];
    udx    = neg_x ? -diff_x : diff_x;
    udy    = neg_y ? -diff_y : diff_y;
    {cum_ovf, cum_sum} = {1'b0, prev_cum} + {1'b0, seg_len};
    p_new  = axis ? step_sat(sa_y, neg_y, arsp.quo, arsp.quo_ovf)
                  : step_sat(sa_x, neg_x, arsp.quo, arsp.quo_ovf);
    last   = IDX_W'(count - CNT_W'(1));
    endp   = (idx == '0 || idx == last - IDX_W'(1)) &&
             ((px == x0 && py == y0) || (px == xl && py == yl));
    out_free = !out_valid || res.ready;
  end

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  // read address by state
  always_comb begin
    rd_addr = scan_i;
    if (state == S_FETCH) begin
      unique case (fcnt)
        3'd0:    rd_addr = idx;
        3'd1:    rd_addr = idx + IDX_W'(1);
        3'd2:    rd_addr = '0;
        default: rd_addr = last;
      endcase
    end
  end

  // commands to the serial unit
  always_comb begin
    acmd         = '0;
    acmd.divisor = seg_len;
    unique case (state)
      S_LEN_GO: begin
        acmd.start = 1'b1;
        acmd.op    = AR_MUL_CLR;
        acmd.a     = udx;
        acmd.b     = udx;
      end
      S_LEN_X: begin
        acmd.start = arsp.done;
        acmd.op    = AR_MUL_ACC;
        acmd.a     = udy;
        acmd.b     = udy;
      end
      S_LEN_Y: begin
        acmd.start = arsp.done && (arsp.acc[ACC_W-1:ACC_W-2] == 2'b00);
        acmd.op    = AR_SQRT;
      end
      S_Q_SETUP: begin
        acmd.start = (seg_len != '0);
        acmd.op    = AR_MUL_CLR;
        acmd.a     = {1'b0, pos_r - cum_idx};
        acmd.b     = udx;
      end
      S_Q_MUL: begin
        acmd.start = arsp.done;
        acmd.op    = AR_DIV;
      end
      S_Q_DIV: begin
        acmd.start = arsp.done && !axis;
        acmd.op    = AR_MUL_CLR;
        acmd.a     = {1'b0, rem};
        acmd.b     = udy;
      end
      default: acmd.start = 1'b0;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (accept && cmd.op == OP_APPEND && count < CNT_FULL) begin
      mem_x[count[IDX_W-1:0]] <= cmd.vertex_x;
      mem_y[count[IDX_W-1:0]] <= cmd.vertex_y;
    end
    if (accept && cmd.op == OP_APPEND && count == '0) begin
      mem_cum[0] <= '0;
    end else if (state == S_LEN_DONE && !is_query) begin
      mem_cum[count[IDX_W-1:0]] <= cum_ovf ? LEN_SAT : cum_sum;
    end
    rd_x   <= mem_x[rd_addr];
    rd_y   <= mem_y[rd_addr];
    rd_cum <= mem_cum[rd_addr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst)         tol <= TOL_W'(1);
    else if (cfg_we) tol <= cfg_wdata;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      chk_v     <= 1'b0;
    end else begin
      if (out_valid && res.ready && state != S_FIN) out_valid <= 1'b0;
      chk_v <= (state == S_SCAN) && (scan_i < last);
      chk_i <= scan_i;
      if (chk_v && rd_cum <= pos_r) idx <= chk_i;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pos_r <= cmd.position;
            unique case (cmd.op)
              OP_CLEAR: count <= '0;
              OP_APPEND: begin
                if (count < CNT_FULL) begin
                  // xl/yl always hold the newest stored vertex
                  sa_x     <= xl;
                  sa_y     <= yl;
                  sb_x     <= cmd.vertex_x;
                  sb_y     <= cmd.vertex_y;
                  xl       <= cmd.vertex_x;
                  yl       <= cmd.vertex_y;
                  is_query <= 1'b0;
                  if (count == '0) begin
                    prev_cum <= '0;
                    count    <= CNT_W'(1);
                  end else begin
                    state <= S_LEN_GO;
                  end
                end
              end
              OP_QUERY: begin
                is_query <= 1'b1;
                idx      <= '0;
                scan_i   <= IDX_W'(1);
                fcnt     <= '0;
                few      <= (count < CNT_W'(2));
                state    <= (count < CNT_W'(2)) ? S_FIN : S_SCAN;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_i >= last) state <= S_FETCH;
          else                scan_i <= scan_i + IDX_W'(1);
        end
        S_FETCH: begin
          fcnt <= fcnt + 3'd1;
          unique case (fcnt)
            3'd1: begin
              sa_x    <= rd_x;
              sa_y    <= rd_y;
              cum_idx <= rd_cum;
            end
            3'd2: begin
              sb_x <= rd_x;
              sb_y <= rd_y;
            end
            3'd3: begin
              x0 <= rd_x;
              y0 <= rd_y;
            end
            3'd4: begin
              xl    <= rd_x;
              yl    <= rd_y;
              total <= rd_cum;
              state <= S_LEN_GO;
            end
            default: ;
          endcase
        end
        S_LEN_GO: state <= S_LEN_X;
        S_LEN_X: begin
          if (arsp.done) state <= S_LEN_Y;
        end
        S_LEN_Y: begin
          if (arsp.done) begin
            if (arsp.acc[ACC_W-1:ACC_W-2] != 2'b00) begin
              seg_len <= LEN_SAT;
              state   <= S_LEN_DONE;
            end else begin
              state <= S_LEN_SQ;
            end
          end
        end
        S_LEN_SQ: begin
          if (arsp.done) begin
            seg_len <= arsp.root;
            state   <= S_LEN_DONE;
          end
        end
        S_LEN_DONE: begin
          if (is_query) begin
            state <= S_Q_SETUP;
          end else begin
            prev_cum <= cum_ovf ? LEN_SAT : cum_sum;
            count    <= count + CNT_W'(1);
            state    <= S_IDLE;
          end
        end
        S_Q_SETUP: begin
          rem  <= pos_r - cum_idx;
          vtx  <= ((pos_r - cum_idx) < {{(LEN_W - TOL_W){1'b0}}, tol}) ||
                  ((pos_r - cum_idx) > seg_len);
          axis <= 1'b0;
          if (seg_len == '0) begin
            px    <= sa_x;
            py    <= sa_y;
            state <= S_FIN;
          end else begin
            state <= S_Q_MUL;
          end
        end
        S_Q_MUL: begin
          if (arsp.done) state <= S_Q_DIV;
        end
        S_Q_DIV: begin
          if (arsp.done) begin
            if (!axis) begin
              px    <= p_new;
              axis  <= 1'b1;
              state <= S_Q_MUL;
            end else begin
              py    <= p_new;
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (few) begin
              o_px     <= '0;
              o_py     <= '0;
              o_idx    <= '0;
              o_vtx    <= 1'b0;
              o_endp   <= 1'b0;
              o_status <= ST_FEW;
            end else begin
              o_px     <= px;
              o_py     <= py;
              o_idx    <= idx;
              o_vtx    <= vtx;
              o_endp   <= endp;
              o_status <= (pos_r > total) ? ST_CLAMPED : ST_OK;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result beat
  assign res.valid         = out_valid;
  assign res.point_x       = o_px;
  assign res.point_y       = o_py;
  assign res.segment_index = o_idx;
  assign res.at_vertex     = o_vtx;
  assign res.at_endpoint   = o_endp;
  assign res.status        = o_status;

endmodule
